// ----- sv/fxq_pkg.sv -----
package fxq_pkg;

  // Raw value format
  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int PROD_W    = 2 * DATA_W;

  // Divider: dividend is |a| shifted up by the fraction bits, one quotient bit per cell
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_INT = 4'd8
  } op_t;

  // How the last stage forms the result
  typedef enum logic [1:0] {
    FIN_PLAIN = 2'd0,
    FIN_MUL   = 2'd1,
    FIN_DIV   = 2'd2
  } fin_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic [OP_W-1:0]          operation;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     a_less;
    logic                     a_equal;
    logic                     a_greater;
    logic                     overflowed;
    logic                     divide_by_zero;
  } rsp_t;

  // Item state carried down the chain of cells
  typedef struct packed {
    fin_t                     fin;
    logic [DATA_W-1:0]        plain_value;
    logic                     a_less;
    logic                     a_equal;
    logic                     a_greater;
    logic                     overflowed;
    logic                     divide_by_zero;
    logic signed [PROD_W-1:0] prod;
    logic                     div_neg;
    logic [DATA_W-1:0]        den;
    logic [DATA_W-1:0]        rem;
    logic [NUM_W-1:0]         nq;
  } stage_t;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ----- sv/fixed_point_q24_8_alu_core.sv -----
// Q24.8 fixed-point ALU: add, sub, mul, div, min, max, inc, dec, integer part.
// Command channel (cmd_valid, cmd_stall, cmd) carries two raw operands and an
// operation code; response channel (rsp_valid, rsp_stall, rsp) returns the
// result value with compare, overflow and divide-by-zero flags, one response
// per command, in command order.
// Every item runs through a front decode cell, a chain of 40 divider cells
// (one quotient bit per cell over the 32+8 bit dividend) and a rounding and
// saturation stage into the output register, whatever the operation.
// Throughput is one item per cycle while the skid entry is free. All cells
// advance together; an output register plus one skid entry decouple the chain
// from the receiver, so while rsp_stall holds a waiting response the chain
// keeps advancing until the next item it delivers is parked in the skid
// entry, and cmd_stall rises only once the skid entry is filled.
// Reset clears all valid bits; no response is pending after reset.
module fixed_point_q24_8_alu_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  fxq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fxq_pkg::rsp_t rsp
);

  logic            en;
  logic            s_vld [0:fxq_pkg::DIV_STEPS];
  fxq_pkg::stage_t s_pay [0:fxq_pkg::DIV_STEPS];
  fxq_pkg::rsp_t   fin_rsp;
  logic            skid_vld;
  fxq_pkg::rsp_t   skid;
  logic            take;
  logic            arrive;

  // Chain advances while the skid entry is free
  assign en        = !skid_vld;
  assign cmd_stall = skid_vld;

  fxq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .vld       (s_vld[0]),
    .stage     (s_pay[0])
  );

  // Divider cells, one quotient bit each
  for (genvar i = 0; i < fxq_pkg::DIV_STEPS; i++) begin : g_cell
    fxq_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .prev_vld (s_vld[i]),
      .prev     (s_pay[i]),
      .vld      (s_vld[i+1]),
      .stage    (s_pay[i+1])
    );
  end

  fxq_finish u_finish (
    .stage (s_pay[fxq_pkg::DIV_STEPS]),
    .rsp   (fin_rsp)
  );

  assign take   = rsp_valid && !rsp_stall;
  assign arrive = en && s_vld[fxq_pkg::DIV_STEPS];

  // Output register and skid entry: refill from skid first, park an item when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (arrive) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        rsp <= skid;
      end
    end else if (arrive) begin
      if (!rsp_valid || take) begin
        rsp <= fin_rsp;
      end else begin
        skid <= fin_rsp;
      end
    end
  end

endmodule

// ----- sv/fxq_front.sv -----
module fxq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           cmd_valid,
  input  fxq_pkg::cmd_t  cmd,
  output logic           vld,
  output fxq_pkg::stage_t stage
);

  logic signed [fxq_pkg::DATA_W-1:0] a;
  logic signed [fxq_pkg::DATA_W-1:0] b;
  logic signed [fxq_pkg::DATA_W:0]   addend;
  logic                              cin;
  logic signed [fxq_pkg::DATA_W:0]   sum;
  logic                              add_ovf;
  logic [fxq_pkg::DATA_W-1:0]        add_val;
  logic signed [fxq_pkg::DATA_W-1:0] shr;
  logic                              int_fix;
  logic [fxq_pkg::DATA_W-1:0]        int_val;
  logic                              lt;
  logic                              eq;
  logic signed [fxq_pkg::PROD_W-1:0] prod;
  logic [fxq_pkg::DATA_W-1:0]        abs_a;
  logic [fxq_pkg::DATA_W-1:0]        abs_b;
  fxq_pkg::stage_t                   stage_next;

  assign a = cmd.operand_a;
  assign b = cmd.operand_b;

  // Compare flags hold for every operation
  assign lt = a < b;
  assign eq = a == b;

  // Shared add/subtract for add, sub, inc and dec
  always_comb begin
    addend = {b[fxq_pkg::DATA_W-1], b};
    cin    = 1'b0;
    case (cmd.operation)
      fxq_pkg::OP_SUB: begin
        addend = ~{b[fxq_pkg::DATA_W-1], b};
        cin    = 1'b1;
      end
      fxq_pkg::OP_INC: addend = (fxq_pkg::DATA_W+1)'(1);
      fxq_pkg::OP_DEC: addend = {(fxq_pkg::DATA_W+1){1'b1}};
      default:         addend = {b[fxq_pkg::DATA_W-1], b};
    endcase
  end

  assign sum     = {a[fxq_pkg::DATA_W-1], a} + addend + (fxq_pkg::DATA_W+1)'(cin);
  assign add_ovf = sum[fxq_pkg::DATA_W] ^ sum[fxq_pkg::DATA_W-1];
  assign add_val = add_ovf ? (sum[fxq_pkg::DATA_W] ? fxq_pkg::SAT_MIN : fxq_pkg::SAT_MAX)
                           : sum[fxq_pkg::DATA_W-1:0];

  // Integer part truncates toward zero: bump negatives that have a fraction
  assign shr     = a >>> fxq_pkg::FRAC_BITS;
  assign int_fix = a[fxq_pkg::DATA_W-1] & (|a[fxq_pkg::FRAC_BITS-1:0]);
  assign int_val = shr + fxq_pkg::DATA_W'(int_fix);

  // Full product, rounded in the last stage
  assign prod = $signed(a) * $signed(b);

  // Divider operands as magnitudes
  assign abs_a = a[fxq_pkg::DATA_W-1] ? (fxq_pkg::DATA_W'(0) - a) : a;
  assign abs_b = b[fxq_pkg::DATA_W-1] ? (fxq_pkg::DATA_W'(0) - b) : b;

  // Decode the operation into the stage item
  always_comb begin
    stage_next.fin            = fxq_pkg::FIN_PLAIN;
    stage_next.plain_value    = '0;
    stage_next.a_less         = lt;
    stage_next.a_equal        = eq;
    stage_next.a_greater      = !lt && !eq;
    stage_next.overflowed     = 1'b0;
    stage_next.divide_by_zero = 1'b0;
    stage_next.prod           = prod;
    stage_next.div_neg        = a[fxq_pkg::DATA_W-1] ^ b[fxq_pkg::DATA_W-1];
    stage_next.den            = abs_b;
    stage_next.rem            = '0;
    stage_next.nq             = {abs_a, {fxq_pkg::FRAC_BITS{1'b0}}};
    unique case (cmd.operation) inside
      fxq_pkg::OP_ADD, fxq_pkg::OP_SUB, fxq_pkg::OP_INC, fxq_pkg::OP_DEC: begin
        stage_next.plain_value = add_val;
        stage_next.overflowed  = add_ovf;
      end
      fxq_pkg::OP_MUL: stage_next.fin = fxq_pkg::FIN_MUL;
      fxq_pkg::OP_DIV: begin
        if (b == '0) begin
          stage_next.divide_by_zero = 1'b1;
        end else begin
          stage_next.fin = fxq_pkg::FIN_DIV;
        end
      end
      fxq_pkg::OP_MIN: stage_next.plain_value = (lt || eq) ? a : b;
      fxq_pkg::OP_MAX: stage_next.plain_value = lt ? b : a;
      fxq_pkg::OP_INT: stage_next.plain_value = int_val;
      default:         stage_next.plain_value = '0;
    endcase
  end

  // Capture the item when the chain advances
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ----- sv/fxq_div_cell.sv -----
module fxq_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            prev_vld,
  input  fxq_pkg::stage_t prev,
  output logic            vld,
  output fxq_pkg::stage_t stage
);

  logic [fxq_pkg::DATA_W:0]   trial;
  logic [fxq_pkg::DATA_W:0]   diff;
  logic                       ge;
  fxq_pkg::stage_t            stage_next;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {prev.rem, prev.nq[fxq_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, prev.den};
  assign ge    = trial >= {1'b0, prev.den};

  always_comb begin
    stage_next     = prev;
    stage_next.rem = ge ? diff[fxq_pkg::DATA_W-1:0] : trial[fxq_pkg::DATA_W-1:0];
    stage_next.nq  = {prev.nq[fxq_pkg::NUM_W-2:0], ge};
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ----- sv/fxq_finish.sv -----
module fxq_finish (
  input  fxq_pkg::stage_t stage,
  output fxq_pkg::rsp_t   rsp
);

  localparam logic [fxq_pkg::PROD_W-1:0] HALF    =
    fxq_pkg::PROD_W'(1) << (fxq_pkg::FRAC_BITS - 1);
  localparam logic [fxq_pkg::PROD_W-1:0] LIM_NEG =
    fxq_pkg::PROD_W'(1) << (fxq_pkg::DATA_W - 1);
  localparam logic [fxq_pkg::PROD_W-1:0] LIM_POS = LIM_NEG - fxq_pkg::PROD_W'(1);

  logic [fxq_pkg::PROD_W-1:0] mul_mag;
  logic [fxq_pkg::PROD_W-1:0] mul_q;
  logic                       div_up;
  logic [fxq_pkg::NUM_W:0]    div_q;
  logic [fxq_pkg::PROD_W-1:0] mag;
  logic                       neg;
  logic                       over;
  logic [fxq_pkg::DATA_W-1:0] rounded;

  // Product rounded half away from zero
  assign mul_mag = stage.prod[fxq_pkg::PROD_W-1] ? (fxq_pkg::PROD_W'(0) - stage.prod)
                                                 : stage.prod;
  assign mul_q   = (mul_mag + HALF) >> fxq_pkg::FRAC_BITS;

  // Quotient rounds up when twice the remainder reaches the divisor
  assign div_up = {stage.rem, 1'b0} >= {1'b0, stage.den};
  assign div_q  = {1'b0, stage.nq} + (fxq_pkg::NUM_W+1)'(div_up);

  // Shared sign and saturation
  assign mag     = (stage.fin == fxq_pkg::FIN_MUL) ? mul_q : fxq_pkg::PROD_W'(div_q);
  assign neg     = (stage.fin == fxq_pkg::FIN_MUL) ? stage.prod[fxq_pkg::PROD_W-1]
                                                   : stage.div_neg;
  assign over    = neg ? (mag > LIM_NEG) : (mag > LIM_POS);
  assign rounded = neg ? (fxq_pkg::DATA_W'(0) - mag[fxq_pkg::DATA_W-1:0])
                       : mag[fxq_pkg::DATA_W-1:0];

  always_comb begin
    rsp.a_less         = stage.a_less;
    rsp.a_equal        = stage.a_equal;
    rsp.a_greater      = stage.a_greater;
    rsp.divide_by_zero = stage.divide_by_zero;
    case (stage.fin) inside
      fxq_pkg::FIN_MUL, fxq_pkg::FIN_DIV: begin
        rsp.result_value = over ? (neg ? fxq_pkg::SAT_MIN : fxq_pkg::SAT_MAX) : rounded;
        rsp.overflowed   = over;
      end
      default: begin
        rsp.result_value = stage.plain_value;
        rsp.overflowed   = stage.overflowed;
      end
    endcase
  end

endmodule
